/* design/ptc_pkg.sv */
// Shared types, constants and helpers for the pressure and temperature compensation block.
package ptc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PressW = 32;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] REG_TEMP_CALIB = 2'd0;
  localparam logic [1:0] REG_PRESS_A    = 2'd1;
  localparam logic [1:0] REG_PRESS_B    = 2'd2;
  localparam logic [1:0] REG_PRESS_C    = 2'd3;

  typedef struct packed {
    logic [RawW-1:0] raw_temp;
    logic [RawW-1:0] raw_press;
  } item_t;

  typedef struct packed {
    logic [TempW-1:0] temp_centi;
    logic [63:0]      num;
    logic [63:0]      den;
  } job_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

/* design/ptc_front.sv */
// Front part: temperature compensation and the pressure dividend and divisor, in stages.
module ptc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  ptc_pkg::item_t         in_item,
  input  logic [47:0]            temp_calib,
  input  logic [63:0]            calib_a,
  input  logic [63:0]            calib_b,
  output logic                   job_vld,
  output ptc_pkg::job_t          job
);

  logic [6:0]  vld_r;
  logic [19:0] rp_r [0:5];
  logic [31:0] a_r, dd_r, fine_r;
  logic [19:0] rt_r;
  logic [31:0] d_s;
  logic [31:0] dd_s;
  logic [31:0] t1, t2, t3;
  logic signed [32:0] v1_r;
  logic signed [63:0] v1sq_r, v1p5_r, v1p2_r, v2_r, w0_r, w_r, num_r;
  logic [18:0] tc_r [1:4];
  logic [31:0] tc_s;
  logic signed [63:0] tcs;
  logic [18:0] tc_sat;

  assign t1 = {16'd0, temp_calib[15:0]};
  assign t2 = {{16{temp_calib[31]}}, temp_calib[31:16]};
  assign t3 = {{16{temp_calib[47]}}, temp_calib[47:32]};
  assign d_s = {16'd0, rt_r[19:4]} - t1;
  assign dd_s = $signed(dd_r) >>> 12;
  assign tc_s = $signed(fine_r * 32'd5 + 32'd128) >>> 8;
  assign tcs = {{32{tc_s[31]}}, tc_s};
  assign tc_sat = (tcs > 64'sd262143) ? 19'h3FFFF :
                  (tcs < -64'sd262144) ? 19'h40000 : tc_s[18:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
    // stage 0
    rt_r     <= in_item.raw_temp;
    rp_r[0]  <= in_item.raw_press;
    // stage 1
    a_r      <= ({15'd0, rt_r[19:3]} - (t1 << 1)) * t2;
    dd_r     <= d_s * d_s;
    rp_r[1]  <= rp_r[0];
    // stage 2
    fine_r   <= ($signed(a_r) >>> 11) + ($signed(dd_s * t3) >>> 14);
    rp_r[2]  <= rp_r[1];
    // stage 3
    tc_r[1]  <= tc_sat;
    v1_r     <= {fine_r[31], fine_r} - 33'sd128000;
    rp_r[3]  <= rp_r[2];
    // stage 4
    tc_r[2]  <= tc_r[1];
    v1sq_r   <= v1_r * v1_r;
    v1p5_r   <= v1_r * $signed(ptc_pkg::sx16(calib_b[15:0]));
    v1p2_r   <= v1_r * $signed(ptc_pkg::sx16(calib_a[31:16]));
    rp_r[4]  <= rp_r[3];
    // stage 5
    tc_r[3]  <= tc_r[2];
    v2_r     <= v1sq_r * $signed(ptc_pkg::sx16(calib_b[31:16])) + (v1p5_r <<< 17)
              + (ptc_pkg::sx16(calib_a[63:48]) << 35);
    w0_r     <= ((v1sq_r * $signed(ptc_pkg::sx16(calib_a[47:32]))) >>> 8)
              + (v1p2_r <<< 12);
    rp_r[5]  <= rp_r[4];
    // stage 6
    tc_r[4]  <= tc_r[3];
    w_r      <= ((64'sh0000800000000000 + w0_r) * $signed({48'd0, calib_a[15:0]})) >>> 33;
    num_r    <= (((64'd1048576 - {44'd0, rp_r[5]}) << 31) - v2_r) * 64'sd3125;
  end

  assign job_vld = vld_r[6];
  assign job.temp_centi = tc_r[4];
  assign job.num = num_r;
  assign job.den = w_r;

endmodule

/* design/ptc_back.sv */
// Back part: iterative signed divide and final pressure correction.
module ptc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_vld,
  input  ptc_pkg::job_t          job,
  input  logic [63:0]            calib_b,
  input  logic [15:0]            calib_c,
  output logic                   busy,
  output logic                   out_strobe,
  output logic [18:0]            out_temp_centi,
  output logic [31:0]            out_press_q24_8,
  output logic                   out_press_valid
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_E1 = 4'b0100, S_FIN = 4'b1000
  } state_t;

  state_t state_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r, quo_r, den_r;
  logic        neg_r, zero_r;
  logic [18:0] tc_r;
  logic signed [63:0] p_r, ph_r, ph2_r, e2_r, prod_r;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic signed [63:0] quo_s, e1, pf;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign busy = (state_r != S_IDLE);
  assign rem_sh = {rem_r[62:0], quo_r[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, den_r};
  assign quo_s = neg_r ? 64'd0 - quo_r : quo_r;
  assign mul_a = cnt_r[1] ? ph2_r[63:32] : ph2_r[31:0];
  assign mul_b = (cnt_r[1:0] == 2'd1) ? ph_r[63:32] : ph_r[31:0];
  assign mul_p = mul_a * mul_b;
  assign e1 = prod_r >>> 25;
  assign pf = ((p_r + e1 + e2_r) >>> 8)
            + ($signed(ptc_pkg::sx16(calib_b[47:32])) <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_FIN) && (cnt_r == 7'd3);
      unique case (state_r)
        S_IDLE: begin
          if (job_vld) begin
            tc_r   <= job.temp_centi;
            zero_r <= (job.den == 64'd0);
            neg_r  <= job.num[63] ^ job.den[63];
            quo_r  <= job.num[63] ? 64'd0 - job.num : job.num;
            den_r  <= job.den[63] ? 64'd0 - job.den : job.den;
            rem_r  <= '0;
            cnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) state_r <= S_E1;
        end
        S_E1: begin
          p_r   <= quo_s;
          ph_r  <= quo_s >>> 13;
          ph2_r <= (quo_s >>> 13) * $signed(ptc_pkg::sx16(calib_c));
          e2_r  <= ($signed(ptc_pkg::sx16(calib_b[63:48])) * quo_s) >>> 19;
          state_r <= S_FIN;
          cnt_r <= '0;
        end
        S_FIN: begin
          cnt_r <= cnt_r + 7'd1;
          unique case (cnt_r[1:0])
            2'd0: prod_r <= mul_p;
            2'd1, 2'd2: prod_r <= prod_r + {mul_p[31:0], 32'd0};
            2'd3: begin
              out_temp_centi <= tc_r;
              out_press_valid <= !zero_r;
              if (zero_r) out_press_q24_8 <= '0;
              else if (pf[63]) out_press_q24_8 <= '0;
              else if (pf[63:32] != 32'd0) out_press_q24_8 <= 32'hFFFFFFFF;
              else out_press_q24_8 <= pf[31:0];
              state_r <= S_IDLE;
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_FIN) else $error("strobe outside finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_press_valid |-> out_press_q24_8 == 32'd0) else $error("bad zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r <= 7'd63) else $error("count overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> cnt_r <= 7'd3) else $error("finish overrun");

endmodule

/* design/pressure_temperature_compensation.sv */
// Top level of the pressure and temperature compensation block.
// A reading is accepted at a rising edge where start is high and busy is low. Its
// result is on the out_ ports, marked by out_strobe, which is high for one cycle,
// after it passes the front stages, the queue, 64 restoring divide steps and the
// final correction. The receiver cannot stall results. Up to two readings can wait
// ahead of the divider, which takes a new one only once it is no longer busy with
// the last; busy is high while two are waiting. The user must make calibration
// writes only while no reading is in flight; the block itself does not enforce this.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  output logic        out_strobe,
  output logic [18:0] out_temp_centi,
  output logic [31:0] out_press_q24_8,
  output logic        out_press_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_calib_r;
  logic [63:0] calib_a_r, calib_b_r;
  logic [15:0] calib_c_r;
  logic [ptc_pkg::QCntW-1:0] occ_r, occ_nxt, qcnt_r, qcnt_nxt;
  logic [ptc_pkg::QPtrW-1:0] wr_r, rd_r;
  ptc_pkg::job_t q_r [0:ptc_pkg::QDepth-1];
  logic        back_busy, job_vld, accept, q_vld, take;
  ptc_pkg::item_t item;
  ptc_pkg::job_t  job;

  assign cfg_ready = 1'b1;
  assign busy = (occ_r == ptc_pkg::QCntW'(ptc_pkg::QDepth));
  assign accept = start && !busy;
  assign q_vld = (qcnt_r != '0);
  assign take = q_vld && !back_busy;
  assign occ_nxt = occ_r + ptc_pkg::QCntW'(accept) - ptc_pkg::QCntW'(take);
  assign qcnt_nxt = qcnt_r + ptc_pkg::QCntW'(job_vld) - ptc_pkg::QCntW'(take);
  assign item.raw_temp = in_raw_temp;
  assign item.raw_press = in_raw_press;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      calib_a_r <= '0;
      calib_b_r <= '0;
      calib_c_r <= '0;
      occ_r <= '0;
      qcnt_r <= '0;
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      qcnt_r <= qcnt_nxt;
      if (job_vld) wr_r <= wr_r + 1'b1;
      if (take) rd_r <= rd_r + 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          ptc_pkg::REG_TEMP_CALIB: temp_calib_r <= cfg_data[47:0];
          ptc_pkg::REG_PRESS_A:    calib_a_r <= cfg_data;
          ptc_pkg::REG_PRESS_B:    calib_b_r <= cfg_data;
          ptc_pkg::REG_PRESS_C:    calib_c_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_vld) q_r[wr_r] <= job;
  end

  ptc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_item(item),
    .temp_calib(temp_calib_r), .calib_a(calib_a_r), .calib_b(calib_b_r),
    .job_vld(job_vld), .job(job)
  );

  ptc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(q_vld), .job(q_r[rd_r]),
    .calib_b(calib_b_r), .calib_c(calib_c_r), .busy(back_busy),
    .out_strobe(out_strobe), .out_temp_centi(out_temp_centi),
    .out_press_q24_8(out_press_q24_8), .out_press_valid(out_press_valid)
  );

endmodule
